@@ hw/rtl/oiss_pkg.sv @@
// Shared types, sizes and bit-search helpers for the ordered integer set.
// No dependencies; used by oiss_ctrl, oiss_dpath and the top level.
`timescale 1ns / 1ps

package oiss_pkg;

    // Key space and the 64-ary tree levels derived from it.
    localparam int KEY_BITS      = 16;
    localparam int SLOT_BITS     = 6;                       // bit inside a 64-bit word
    localparam int WORD_BITS     = 1 << SLOT_BITS;          // 64
    localparam int WIDX_BITS     = KEY_BITS - SLOT_BITS;    // leaf word index
    localparam int MIDX_BITS     = WIDX_BITS - SLOT_BITS;   // middle word index
    localparam int LEAF_WORDS    = 1 << WIDX_BITS;
    localparam int MID_WORDS     = 1 << MIDX_BITS;

    typedef logic [2:0] mode_t;
    localparam mode_t MODE_INSERT = 3'd0;
    localparam mode_t MODE_DELETE = 3'd1;
    localparam mode_t MODE_MEMBER = 3'd2;
    localparam mode_t MODE_SUCC   = 3'd3;
    localparam mode_t MODE_PRED   = 3'd4;

    typedef logic [WORD_BITS-1:0] word_t;

    // Controller -> datapath commands.
    typedef struct packed {
        logic capture;    // accept beat, latch payload, read leaf word
        logic clr_write;  // clearing sweep write
        logic leaf_op;    // update / member / in-word search
        logic mid_srch;   // search middle word of the key
        logic top_srch;   // search top summary
        logic midtop;     // take extreme of middle word picked from top
        logic leaf2;      // extreme of the fetched neighbour leaf word
    } cmd_t;

    // Datapath -> controller status.
    typedef struct packed {
        logic clr_last;
        logic search;
        logic hit;
    } stat_t;

    // Lowest set bit; result undefined (0) for zero input.
    function automatic logic [SLOT_BITS-1:0] low_bit(input word_t x);
        logic [SLOT_BITS-1:0] n;
        n = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (x[i]) begin
                n = SLOT_BITS'(i);
            end
        end
        return n;
    endfunction

    // Highest set bit; 0 for zero input.
    function automatic logic [SLOT_BITS-1:0] high_bit(input word_t x);
        logic [SLOT_BITS-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (x[i]) begin
                n = SLOT_BITS'(i);
            end
        end
        return n;
    endfunction

    // Bits of x strictly above position b.
    function automatic word_t bits_above(input word_t x, input logic [SLOT_BITS-1:0] b);
        logic [SLOT_BITS-1:0] sh;
        sh = SLOT_BITS'(WORD_BITS - 1) - b;
        return x & ~({WORD_BITS{1'b1}} >> sh);
    endfunction

    // Bits of x strictly below position b.
    function automatic word_t bits_below(input word_t x, input logic [SLOT_BITS-1:0] b);
        return x & ~({WORD_BITS{1'b1}} << b);
    endfunction

endpackage

@@ hw/rtl/oiss_ctrl.sv @@
// Sequencing state machine for the ordered integer set.
// Depends on oiss_pkg (cmd_t, stat_t).
`timescale 1ns / 1ps

module oiss_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  oiss_pkg::stat_t stat,
    output oiss_pkg::cmd_t  cmd,
    output logic            busy
);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_LEAF   = 7'b0000100,
        ST_MID    = 7'b0001000,
        ST_TOP    = 7'b0010000,
        ST_MIDTOP = 7'b0100000,
        ST_LEAF2  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LEAF;
                end
            end
            ST_LEAF:
            begin
                cmd.leaf_op = 1'b1;
                state_next  = (stat.search && !stat.hit) ? ST_MID : ST_IDLE;
            end
            ST_MID:
            begin
                cmd.mid_srch = 1'b1;
                state_next   = stat.hit ? ST_LEAF2 : ST_TOP;
            end
            ST_TOP:
            begin
                cmd.top_srch = 1'b1;
                state_next   = stat.hit ? ST_MIDTOP : ST_IDLE;
            end
            ST_MIDTOP:
            begin
                cmd.midtop = 1'b1;
                state_next = stat.hit ? ST_LEAF2 : ST_IDLE;
            end
            ST_LEAF2:
            begin
                cmd.leaf2  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_capture_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> busy && !cmd.capture)
        else $error("capture not followed by busy work");
`endif

endmodule

@@ hw/rtl/oiss_dpath.sv @@
// Datapath: leaf bitmap memory, middle and top summaries, shared bit search.
// Depends on oiss_pkg; driven by oiss_ctrl commands.
`timescale 1ns / 1ps

module oiss_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  oiss_pkg::cmd_t                cmd,
    output oiss_pkg::stat_t               stat,
    input  logic [2:0]                    mode,
    input  logic [oiss_pkg::KEY_BITS-1:0] key,
    output logic                          done,
    output logic                          found,
    output logic [oiss_pkg::KEY_BITS-1:0] neighbour_key
);

    // Leaf bitmap memory, one bit per key.
    oiss_pkg::word_t leaf_mem [oiss_pkg::LEAF_WORDS];
    oiss_pkg::word_t leaf_q_reg;

    // Middle summary words and top summary.
    oiss_pkg::word_t                    mid_reg [oiss_pkg::MID_WORDS];
    logic [oiss_pkg::MID_WORDS-1:0]     top_reg;

    oiss_pkg::mode_t                    mode_reg;
    logic [oiss_pkg::KEY_BITS-1:0]      key_reg;
    logic [oiss_pkg::WIDX_BITS-1:0]     w2_reg;
    logic [oiss_pkg::MIDX_BITS-1:0]     m2_reg;
    logic [oiss_pkg::WIDX_BITS-1:0]     clr_cnt_reg;

    logic                               done_reg;
    logic                               found_reg;
    logic [oiss_pkg::KEY_BITS-1:0]      nkey_reg;

    logic [oiss_pkg::SLOT_BITS-1:0]     pos;
    logic [oiss_pkg::SLOT_BITS-1:0]     wlo;
    logic [oiss_pkg::WIDX_BITS-1:0]     w_idx;
    logic [oiss_pkg::MIDX_BITS-1:0]     m_idx;
    logic                               is_succ;
    logic                               is_ins;
    logic                               is_del;
    logic                               is_mem;
    logic                               is_search;

    oiss_pkg::word_t                    bitmask;
    oiss_pkg::word_t                    wbit;
    oiss_pkg::word_t                    leaf_new;
    oiss_pkg::word_t                    mid_rd;
    oiss_pkg::word_t                    mid_new;
    logic [oiss_pkg::MIDX_BITS-1:0]     mid_rd_addr;
    oiss_pkg::word_t                    top_w;
    oiss_pkg::word_t                    enc_vec;
    logic                               enc_hit;
    logic [oiss_pkg::SLOT_BITS-1:0]     enc_idx;
    logic [oiss_pkg::WIDX_BITS-1:0]     w2_next;

    logic                               rd_en;
    logic [oiss_pkg::WIDX_BITS-1:0]     rd_addr;
    logic                               wr_en;
    logic [oiss_pkg::WIDX_BITS-1:0]     wr_addr;
    oiss_pkg::word_t                    wr_data;

    logic                               emit;
    logic                               emit_found;
    logic [oiss_pkg::KEY_BITS-1:0]      emit_key;

    assign pos   = key_reg[oiss_pkg::SLOT_BITS-1:0];
    assign w_idx = key_reg[oiss_pkg::KEY_BITS-1:oiss_pkg::SLOT_BITS];
    assign wlo   = w_idx[oiss_pkg::SLOT_BITS-1:0];
    assign m_idx = w_idx[oiss_pkg::WIDX_BITS-1:oiss_pkg::SLOT_BITS];

    assign is_succ   = (mode_reg == oiss_pkg::MODE_SUCC);
    assign is_ins    = (mode_reg == oiss_pkg::MODE_INSERT);
    assign is_del    = (mode_reg == oiss_pkg::MODE_DELETE);
    assign is_mem    = (mode_reg == oiss_pkg::MODE_MEMBER);
    assign is_search = is_succ || (mode_reg == oiss_pkg::MODE_PRED);

    assign bitmask  = oiss_pkg::word_t'(1) << pos;
    assign wbit     = oiss_pkg::word_t'(1) << wlo;
    assign leaf_new = is_ins ? (leaf_q_reg | bitmask) : (leaf_q_reg & ~bitmask);

    assign mid_rd_addr = cmd.midtop ? m2_reg : m_idx;
    assign mid_rd      = mid_reg[mid_rd_addr];
    assign mid_new     = mid_rd & ~wbit;
    assign top_w       = oiss_pkg::word_t'(top_reg);

    // One bit-search unit shared by every level.
    always_comb
    begin
        priority if (cmd.leaf_op)
        begin
            enc_vec = is_succ ? oiss_pkg::bits_above(leaf_q_reg, pos)
                              : oiss_pkg::bits_below(leaf_q_reg, pos);
        end
        else if (cmd.mid_srch)
        begin
            enc_vec = is_succ ? oiss_pkg::bits_above(mid_rd, wlo)
                              : oiss_pkg::bits_below(mid_rd, wlo);
        end
        else if (cmd.top_srch)
        begin
            enc_vec = is_succ
                ? oiss_pkg::bits_above(top_w, oiss_pkg::SLOT_BITS'(m_idx))
                : oiss_pkg::bits_below(top_w, oiss_pkg::SLOT_BITS'(m_idx));
        end
        else if (cmd.midtop)
        begin
            enc_vec = mid_rd;
        end
        else if (cmd.leaf2)
        begin
            enc_vec = leaf_q_reg;
        end
        else
        begin
            enc_vec = '0;
        end
    end

    assign enc_hit = |enc_vec;
    assign enc_idx = is_succ ? oiss_pkg::low_bit(enc_vec) : oiss_pkg::high_bit(enc_vec);

    assign stat.clr_last = (clr_cnt_reg == oiss_pkg::WIDX_BITS'(oiss_pkg::LEAF_WORDS - 1));
    assign stat.search   = is_search;
    assign stat.hit      = enc_hit;

    // Leaf memory ports.
    assign w2_next = cmd.midtop ? {m2_reg, enc_idx} : {m_idx, enc_idx};
    assign rd_en   = cmd.capture || ((cmd.mid_srch || cmd.midtop) && enc_hit);
    assign rd_addr = cmd.capture ? key[oiss_pkg::KEY_BITS-1:oiss_pkg::SLOT_BITS] : w2_next;
    assign wr_en   = cmd.clr_write || (cmd.leaf_op && (is_ins || is_del));
    assign wr_addr = cmd.clr_write ? clr_cnt_reg : w_idx;
    assign wr_data = cmd.clr_write ? '0 : leaf_new;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            leaf_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            leaf_q_reg <= leaf_mem[rd_addr];
        end
    end

    // Result selection.
    always_comb
    begin
        emit       = 1'b0;
        emit_found = 1'b0;
        emit_key   = '0;
        if (cmd.leaf_op && is_mem)
        begin
            emit       = 1'b1;
            emit_found = leaf_q_reg[pos];
        end
        else if (cmd.leaf_op && is_search && enc_hit)
        begin
            emit       = 1'b1;
            emit_found = 1'b1;
            emit_key   = {w_idx, enc_idx};
        end
        else if ((cmd.top_srch || cmd.midtop) && !enc_hit)
        begin
            emit = 1'b1;
        end
        else if (cmd.leaf2)
        begin
            emit       = 1'b1;
            emit_found = enc_hit;
            emit_key   = enc_hit ? {w2_reg, enc_idx} : '0;
        end
    end

    // Payload and pointer registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            key_reg  <= key;
        end
        if ((cmd.mid_srch || cmd.midtop) && enc_hit)
        begin
            w2_reg <= w2_next;
        end
        if (cmd.top_srch)
        begin
            m2_reg <= enc_idx[oiss_pkg::MIDX_BITS-1:0];
        end
        if (emit)
        begin
            found_reg <= emit_found;
            nkey_reg  <= emit_key;
        end
    end

    // Summaries, sweep counter and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < oiss_pkg::MID_WORDS; i++)
            begin
                mid_reg[i] <= '0;
            end
            top_reg     <= '0;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= emit;
            if (cmd.clr_write)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.leaf_op && is_ins)
            begin
                mid_reg[m_idx] <= mid_rd | wbit;
                top_reg[m_idx] <= 1'b1;
            end
            else if (cmd.leaf_op && is_del && (leaf_new == '0))
            begin
                mid_reg[m_idx] <= mid_new;
                if (mid_new == '0)
                begin
                    top_reg[m_idx] <= 1'b0;
                end
            end
        end
    end

    assign done          = done_reg;
    assign found         = found_reg;
    assign neighbour_key = nkey_reg;

`ifndef SYNTHESIS
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("results on consecutive cycles");

    a_done_mode: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (mode_reg == oiss_pkg::MODE_MEMBER) || (mode_reg == oiss_pkg::MODE_SUCC)
                 || (mode_reg == oiss_pkg::MODE_PRED))
        else $error("result for a mode that gives none");

    // key_reg holds no value until the first beat is taken
    a_top_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(key_reg) |-> (top_reg[m_idx] == (mid_reg[m_idx] != '0)))
        else $error("top summary out of step with middle summary");
`endif

endmodule

@@ hw/rtl/ordered_integer_set_successor.sv @@
// Top level of the ordered integer set with successor/predecessor search.
// Depends on oiss_pkg, oiss_ctrl and oiss_dpath.
`timescale 1ns / 1ps

// Ordered integer set over 16-bit keys, kept as a three-level 64-ary bitmap
// tree (1024 x 64 leaf memory, 16 x 64 middle summary, 16-bit top summary).
// After reset the block sweeps the leaf memory to zero, one word a cycle, and
// holds busy high through the sweep. An item (mode, key) is taken at a rising
// edge with start high and busy low. Insert and delete give no result;
// member, successor and predecessor give one beat on done/found/
// neighbour_key, valid for exactly one cycle: the receiver cannot stall it,
// so it must capture the beat when done is high. Modes 5 to 7 are accepted
// and ignored. Insert, delete, member, and searches answered inside the key's
// own leaf word pass through the leaf step only; a neighbour in the same
// middle word adds the middle search and a fetch of that leaf word; else the
// top summary is searched, then the middle word it picks, then its leaf word.
// The leaf memory's single registered read port gives each tree access a step
// of its own. The result beat appears on the cycle the block returns to idle,
// so the next item may be started while the result is being shown.

module ordered_integer_set_successor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    mode,
    input  logic [oiss_pkg::KEY_BITS-1:0] key,
    output logic                          done,
    output logic                          found,
    output logic [oiss_pkg::KEY_BITS-1:0] neighbour_key
);

    oiss_pkg::cmd_t  cmd;
    oiss_pkg::stat_t stat;

    // State machine: clearing sweep, then a state for each step through the tree levels.
    oiss_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Storage, shared bit search and result register.
    oiss_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .mode          (mode),
        .key           (key),
        .done          (done),
        .found         (found),
        .neighbour_key (neighbour_key)
    );

endmodule

@@ test/ordered_integer_set_successor_tb.sv @@
// Self-checking testbench for ordered_integer_set_successor (insert, delete, member,
// successor and predecessor on a 16-bit key set). Depends on oiss_pkg and the RTL top.
`timescale 1ns / 1ps

module ordered_integer_set_successor_tb;

    // Key and tree index types at the block's widths.
    typedef logic [oiss_pkg::KEY_BITS-1:0]  key_t;
    typedef logic [oiss_pkg::SLOT_BITS-1:0] slot_t;
    typedef logic [oiss_pkg::WIDX_BITS-1:0] widx_t;
    typedef logic [oiss_pkg::MIDX_BITS-1:0] midx_t;

    // Modes above MODE_PRED are accepted by the block and dropped.
    localparam oiss_pkg::mode_t MODE_RSVD5 = 3'd5;
    localparam oiss_pkg::mode_t MODE_RSVD6 = 3'd6;
    localparam oiss_pkg::mode_t MODE_RSVD7 = 3'd7;

    localparam int IDLE_MAX      = 13;    // longest sender gap, in cycles
    localparam int RANDOM_BLOCKS = 9;
    localparam int BLOCK_ITEMS   = 200;   // 9 x 200 random beats
    localparam int DRAIN_CYCLES  = 16;    // settle time after the last result
    // No accept and no result for this long means the block hung. The limit lies
    // well above the reset sweep and the longest beat plus the longest sender gap.
    localparam int STALL_LIMIT   = 5000;

    // One expected result beat.
    typedef struct packed {
        logic found;
        key_t nkey;
    } answer_t;

    // One directed row; typed = 1 means the answer is written in the row.
    typedef struct packed {
        oiss_pkg::mode_t md;
        key_t            k;
        logic            typed;
        logic            exp_found;
        key_t            exp_key;
    } stim_row_t;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    oiss_pkg::mode_t mode;
    key_t            key;
    logic            done;
    logic            found;
    key_t            neighbour_key;

    // Shadow copy of the three-level bitmap tree.
    oiss_pkg::word_t  leaf_map [oiss_pkg::LEAF_WORDS];
    oiss_pkg::word_t  mid_map  [oiss_pkg::MID_WORDS];
    logic [oiss_pkg::MID_WORDS-1:0] top_map;

    key_t    held_keys[$];          // keys currently in the set, any order
    answer_t expected_answers[$];   // results still owed by the block, oldest first
    answer_t oldest_answer;

    int unsigned ins_pct;           // per-block insert share, percent
    int unsigned del_pct;           // per-block delete share, percent
    key_t        cluster_base;      // per-block hot region
    logic        burst;             // per-block: no idle cycles at all
    int          fail_count;
    int          stall_cycles;

    // Directed rows. Walk: empty-set queries, absent delete, both key extremes,
    // duplicate insert, neighbours that need the top summary, an in-middle-word
    // neighbour, unused modes, delete down to a sparse set.
    stim_row_t directed_rows [25] = '{
        '{oiss_pkg::MODE_MEMBER, 16'h0000, 1'b1, 1'b0, 16'h0000},
        '{oiss_pkg::MODE_SUCC,   16'h0000, 1'b1, 1'b0, 16'h0000},
        '{oiss_pkg::MODE_PRED,   16'hFFFF, 1'b1, 1'b0, 16'h0000},
        '{oiss_pkg::MODE_DELETE, 16'h0005, 1'b0, 1'b0, 16'h0000},
        '{oiss_pkg::MODE_INSERT, 16'h0000, 1'b0, 1'b0, 16'h0000},
        '{oiss_pkg::MODE_INSERT, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
        '{oiss_pkg::MODE_INSERT, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
        '{oiss_pkg::MODE_MEMBER, 16'hFFFF, 1'b1, 1'b1, 16'h0000},
        '{oiss_pkg::MODE_SUCC,   16'h0000, 1'b1, 1'b1, 16'hFFFF},
        '{oiss_pkg::MODE_PRED,   16'hFFFF, 1'b1, 1'b1, 16'h0000},
        '{oiss_pkg::MODE_SUCC,   16'hFFFF, 1'b1, 1'b0, 16'h0000},
        '{oiss_pkg::MODE_PRED,   16'h0000, 1'b1, 1'b0, 16'h0000},
        '{oiss_pkg::MODE_INSERT, 16'h0040, 1'b0, 1'b0, 16'h0000},
        '{oiss_pkg::MODE_INSERT, 16'h1234, 1'b0, 1'b0, 16'h0000},
        '{oiss_pkg::MODE_SUCC,   16'h0001, 1'b0, 1'b0, 16'h0000},
        '{oiss_pkg::MODE_PRED,   16'h1233, 1'b0, 1'b0, 16'h0000},
        '{oiss_pkg::MODE_SUCC,   16'h0FFF, 1'b0, 1'b0, 16'h0000},
        '{MODE_RSVD5,            16'h1234, 1'b0, 1'b0, 16'h0000},
        '{MODE_RSVD6,            16'h0000, 1'b0, 1'b0, 16'h0000},
        '{MODE_RSVD7,            16'hFFFF, 1'b0, 1'b0, 16'h0000},
        '{oiss_pkg::MODE_DELETE, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
        '{oiss_pkg::MODE_DELETE, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
        '{oiss_pkg::MODE_SUCC,   16'h1234, 1'b0, 1'b0, 16'h0000},
        '{oiss_pkg::MODE_PRED,   16'hAAAA, 1'b0, 1'b0, 16'h0000},
        '{oiss_pkg::MODE_MEMBER, 16'h5555, 1'b0, 1'b0, 16'h0000}
    };

    ordered_integer_set_successor u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .key           (key),
        .done          (done),
        .found         (found),
        .neighbour_key (neighbour_key)
    );

    // 10 ns clock, rising edges at 5, 15, ...
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Set predictor
    // ------------------------------------------------------------------

    // Position of the lowest set bit; x is nonzero.
    function automatic slot_t lowest_one(input oiss_pkg::word_t x);
        int i;
        i = 0;
        while (i < oiss_pkg::WORD_BITS - 1 && !x[i])
            i++;
        return slot_t'(i);
    endfunction

    // Position of the highest set bit; x is nonzero.
    function automatic slot_t highest_one(input oiss_pkg::word_t x);
        int i;
        i = oiss_pkg::WORD_BITS - 1;
        while (i > 0 && !x[i])
            i--;
        return slot_t'(i);
    endfunction

    // Positions strictly above b (up) or strictly below b.
    function automatic oiss_pkg::word_t side_mask(input logic up, input slot_t b);
        return up ? ({oiss_pkg::WORD_BITS{1'b1}} << b << 1)
                  : ((oiss_pkg::word_t'(1) << b) - oiss_pkg::word_t'(1));
    endfunction

    function automatic slot_t nearest_end(input logic up, input oiss_pkg::word_t x);
        return up ? lowest_one(x) : highest_one(x);
    endfunction

    // Successor (up) or predecessor of k in the shadow tree. Tries the key's
    // leaf word, then its middle word, then the top summary.
    function automatic answer_t neighbour_of(input logic up, input key_t k);
        answer_t         ans;
        widx_t           w;
        midx_t           m;
        oiss_pkg::word_t t;
        logic            hit;
        ans = '0;
        w   = k[oiss_pkg::KEY_BITS-1:oiss_pkg::SLOT_BITS];
        m   = w[oiss_pkg::WIDX_BITS-1:oiss_pkg::SLOT_BITS];
        t   = leaf_map[w] & side_mask(up, k[oiss_pkg::SLOT_BITS-1:0]);
        if (t != '0)
        begin
            ans.found = 1'b1;
            ans.nkey  = {w, nearest_end(up, t)};
        end
        else
        begin
            t   = mid_map[m] & side_mask(up, w[oiss_pkg::SLOT_BITS-1:0]);
            hit = (t != '0);
            if (!hit)
            begin
                t = oiss_pkg::word_t'(top_map) & side_mask(up, slot_t'(m));
                if (t != '0)
                begin
                    m   = midx_t'(nearest_end(up, t));
                    t   = mid_map[m];
                    hit = 1'b1;
                end
            end
            if (hit)
            begin
                w         = {m, nearest_end(up, t)};
                ans.found = 1'b1;
                ans.nkey  = {w, nearest_end(up, leaf_map[w])};
            end
        end
        return ans;
    endfunction

    // Apply one accepted beat to the shadow set and queue the answer it owes.
    // A typed answer from the directed table replaces the predicted one.
    task automatic absorb_beat(input oiss_pkg::mode_t md, input key_t k, input logic typed,
                               input answer_t typed_ans);
        widx_t   w;
        midx_t   m;
        slot_t   s;
        answer_t ans;
        w = k[oiss_pkg::KEY_BITS-1:oiss_pkg::SLOT_BITS];
        m = w[oiss_pkg::WIDX_BITS-1:oiss_pkg::SLOT_BITS];
        s = k[oiss_pkg::SLOT_BITS-1:0];
        ans = '0;
        case (md)
            oiss_pkg::MODE_INSERT:
            begin
                // duplicate insert leaves everything as is
                if (!leaf_map[w][s])
                begin
                    leaf_map[w][s]                         = 1'b1;
                    mid_map[m][w[oiss_pkg::SLOT_BITS-1:0]] = 1'b1;
                    top_map[m]                             = 1'b1;
                    held_keys.push_back(k);
                end
            end
            oiss_pkg::MODE_DELETE:
            begin
                // deleting an absent key is a no-op
                if (leaf_map[w][s])
                begin
                    leaf_map[w][s] = 1'b0;
                    if (leaf_map[w] == '0)
                    begin
                        mid_map[m][w[oiss_pkg::SLOT_BITS-1:0]] = 1'b0;
                        if (mid_map[m] == '0)
                            top_map[m] = 1'b0;
                    end
                    foreach (held_keys[i])
                    begin
                        if (held_keys[i] == k)
                        begin
                            held_keys.delete(i);
                            break;
                        end
                    end
                end
            end
            oiss_pkg::MODE_MEMBER:
            begin
                ans.found = leaf_map[w][s];
                expected_answers.push_back(typed ? typed_ans : ans);
            end
            oiss_pkg::MODE_SUCC:
                expected_answers.push_back(typed ? typed_ans : neighbour_of(1'b1, k));
            oiss_pkg::MODE_PRED:
                expected_answers.push_back(typed ? typed_ans : neighbour_of(1'b0, k));
            default:
                ;   // unused modes: no state change, no result
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Key mix: anywhere, inside the block's hot region, or near either end.
    function automatic key_t scatter_key();
        key_t        k;
        int unsigned off;
        case ($urandom_range(0, 3))
            0: k = key_t'($urandom);
            3:
            begin
                off = $urandom_range(0, 70);
                k   = $urandom_range(0, 1) ? key_t'(off) : ~key_t'(off);
            end
            default: k = key_t'(cluster_base + key_t'($urandom_range(0, 511)));
        endcase
        return k;
    endfunction

    // Deletes mostly hit keys that are present so the set can shrink to
    // empty; with keys present, half the queries land on or right next to one.
    function automatic void pick_item(output oiss_pkg::mode_t md, output key_t k);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < ins_pct)
        begin
            md = oiss_pkg::MODE_INSERT;
            k  = scatter_key();
        end
        else if (roll < ins_pct + del_pct)
        begin
            md = oiss_pkg::MODE_DELETE;
            if (held_keys.size() != 0 && $urandom_range(0, 7) != 0)
                k = held_keys[$urandom_range(0, held_keys.size() - 1)];
            else
                k = scatter_key();
        end
        else if (roll < 96)
        begin
            case ($urandom_range(0, 2))
                0:       md = oiss_pkg::MODE_MEMBER;
                1:       md = oiss_pkg::MODE_SUCC;
                default: md = oiss_pkg::MODE_PRED;
            endcase
            if (held_keys.size() != 0 && $urandom_range(0, 1) != 0)
                k = key_t'(int'(held_keys[$urandom_range(0, held_keys.size() - 1)])
                           + int'($urandom_range(0, 4)) - 2);
            else
                k = scatter_key();
        end
        else
        begin
            md = oiss_pkg::mode_t'($urandom_range(MODE_RSVD5, MODE_RSVD7));
            k  = key_t'($urandom);
        end
    endfunction

    // Present one beat after gap idle cycles and return at the edge that
    // takes it. Called at a rising edge; start is touched once per step, so
    // back-to-back beats keep start high.
    task automatic drive_beat(input oiss_pkg::mode_t md, input key_t k,
                              input int unsigned gap);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        mode  <= md;
        key   <= k;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result checker: done is a one-cycle strobe, sampled at the edge that
    // ends its cycle. Results come back in beat order.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_answers.size() == 0)
            begin
                $error("result with none pending: found=%0b neighbour_key=%h",
                       found, neighbour_key);
                fail_count++;
            end
            else
            begin
                oldest_answer = expected_answers.pop_front();
                if (found !== oldest_answer.found)
                begin
                    $error("found: expected %0b, got %0b", oldest_answer.found, found);
                    fail_count++;
                end
                if (neighbour_key !== oldest_answer.nkey)
                begin
                    $error("neighbour_key: expected %h, got %h",
                           oldest_answer.nkey, neighbour_key);
                    fail_count++;
                end
            end
        end
    end

    // Hang detector: any accepted beat or result clears the count.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        oiss_pkg::mode_t md;
        key_t            k;
        answer_t         typed_ans;

        fail_count   = 0;
        stall_cycles = 0;
        foreach (leaf_map[i])
            leaf_map[i] = '0;
        foreach (mid_map[i])
            mid_map[i] = '0;
        top_map = '0;

        start <= 1'b0;
        mode  <= oiss_pkg::MODE_INSERT;
        key   <= '0;
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The first beat waits out the reset sweep on busy.
        foreach (directed_rows[i])
        begin
            typed_ans.found = directed_rows[i].exp_found;
            typed_ans.nkey  = directed_rows[i].exp_key;
            drive_beat(directed_rows[i].md, directed_rows[i].k, $urandom_range(0, IDLE_MAX));
            absorb_beat(directed_rows[i].md, directed_rows[i].k, directed_rows[i].typed,
                        typed_ans);
        end

        // Random part in blocks. Low-insert blocks keep the set sparse, so
        // neighbours are often found only through the top summary; high-insert
        // blocks fill whole leaf words around the hot region. Some blocks run
        // with no idle cycles at all.
        typed_ans = '0;
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            case ($urandom_range(0, 2))
                0:       ins_pct = 12;
                1:       ins_pct = 30;
                default: ins_pct = 45;
            endcase
            del_pct      = $urandom_range(0, 1) ? 30 : 15;
            cluster_base = key_t'($urandom);
            burst        = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < BLOCK_ITEMS; n++)
            begin
                pick_item(md, k);
                drive_beat(md, k, burst ? 0 : $urandom_range(0, IDLE_MAX));
                absorb_beat(md, k, 1'b0, typed_ans);
            end
        end
        start <= 1'b0;

        // Drain: every owed result, then a settle time for any stray strobe.
        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
